/* rtl/core/msdr_pkg.sv */
`default_nettype none

package msdr_pkg;

    // field widths
    localparam int SpeedWidth = 16;
    localparam int DutyWidth  = 12;
    localparam int StepWidth  = 8;
    localparam int ShiftWidth = 4;
    localparam int MaxShift   = 8;

    // divider sizing: shifted error over speed change plus one
    localparam int DividendWidth = SpeedWidth + MaxShift;
    localparam int DivisorWidth  = SpeedWidth + 1;
    localparam int CorrWidth     = 16;
    localparam int DivCountWidth = $clog2(DividendWidth + 1);

    // stream and configuration port widths
    localparam int InDataWidth  = 24;
    localparam int OutDataWidth = 16;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 16;

    // register reset values
    localparam logic [StepWidth-1:0]  StartupStepReset = 8'd20;
    localparam logic [DutyWidth-1:0]  StartupCapReset  = 12'd800;
    localparam logic [DutyWidth-1:0]  DutyCeilReset    = 12'd4000;
    localparam logic [ShiftWidth-1:0] GainShiftReset   = 4'd4;

    // configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_RUN_ENABLE   = 3'd0,
        CFG_TARGET_SPEED = 3'd1,
        CFG_STARTUP_STEP = 3'd2,
        CFG_STARTUP_CAP  = 3'd3,
        CFG_DUTY_CEILING = 3'd4,
        CFG_GAIN_SHIFT   = 3'd5
    } cfg_idx_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_UPDATE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic commit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/msdr_div.sv */
`default_nettype none

module msdr_div
    import msdr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DividendWidth-1:0] dividend,
    input  wire logic [DivisorWidth-1:0]  divisor,
    output logic                          done,
    output logic [CorrWidth-1:0]          quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DivCountWidth-1:0] count_reg, count_next;
    logic [DividendWidth-1:0] quo_reg, quo_next;
    logic [DivisorWidth-1:0]  rem_reg, rem_next;
    logic [DivisorWidth-1:0]  dsr_reg, dsr_next;
    logic [DivisorWidth:0]    partial;
    logic [DivisorWidth:0]    trial;

    // one restoring step per cycle
    always_comb
    begin
        partial    = {rem_reg, quo_reg[DividendWidth-1]};
        trial      = partial - {1'b0, dsr_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = DivCountWidth'(DividendWidth);
            quo_next   = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DivisorWidth])
            begin
                rem_next = partial[DivisorWidth-1:0];
                quo_next = {quo_reg[DividendWidth-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DivisorWidth-1:0];
                quo_next = {quo_reg[DividendWidth-2:0], 1'b1};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == DivCountWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[CorrWidth-1:0];

endmodule

`default_nettype wire

/* rtl/core/msdr_dp.sv */
`default_nettype none

module msdr_dp
    import msdr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    input  wire logic [InDataWidth-1:0]  s_tdata,
    input  wire logic                    m_tready,
    output logic                         m_tvalid,
    output logic [OutDataWidth-1:0]      m_tdata,
    input  wire cmd_t                    cmd,
    output status_t                      status
);

    // configuration registers
    logic                  run_enable_reg;
    logic [SpeedWidth-1:0] target_reg;
    logic [StepWidth-1:0]  step_reg;
    logic [DutyWidth-1:0]  cap_reg;
    logic [DutyWidth-1:0]  ceil_reg;
    logic [ShiftWidth-1:0] shift_reg;

    // regulator state
    logic [DutyWidth-1:0]  duty_level_reg, duty_level_next;
    logic [SpeedWidth-1:0] prev_speed_reg;

    // latched input transaction
    logic [SpeedWidth-1:0] speed_reg;
    logic                  running_reg;
    logic                  fresh_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [DutyWidth-1:0]  out_duty_reg;
    logic                  out_capped_reg;

    logic                     enabled;
    logic [SpeedWidth-1:0]    change;
    logic [SpeedWidth-1:0]    err;
    logic [ShiftWidth-1:0]    shift_sat;
    logic [DividendWidth-1:0] dividend;
    logic [DivisorWidth-1:0]  divisor;
    logic                     div_done;
    logic [CorrWidth-1:0]     corr;
    logic [DutyWidth:0]       ramp_sum;
    logic [CorrWidth:0]       up_sum;
    logic                     capped_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg <= 1'b0;
            target_reg     <= '0;
            step_reg       <= StartupStepReset;
            cap_reg        <= StartupCapReset;
            ceil_reg       <= DutyCeilReset;
            shift_reg      <= GainShiftReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RUN_ENABLE:   run_enable_reg <= cfg_data[0];
                CFG_TARGET_SPEED: target_reg     <= cfg_data[SpeedWidth-1:0];
                CFG_STARTUP_STEP: step_reg       <= cfg_data[StepWidth-1:0];
                CFG_STARTUP_CAP:  cap_reg        <= cfg_data[DutyWidth-1:0];
                CFG_DUTY_CEILING: ceil_reg       <= cfg_data[DutyWidth-1:0];
                CFG_GAIN_SHIFT:   shift_reg      <= cfg_data[ShiftWidth-1:0];
                default:          ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            speed_reg   <= s_tdata[SpeedWidth-1:0];
            running_reg <= s_tdata[SpeedWidth];
            fresh_reg   <= s_tdata[SpeedWidth+1];
        end
    end

    // divider operands
    always_comb
    begin
        enabled   = run_enable_reg && (target_reg != '0);
        change    = (speed_reg >= prev_speed_reg) ? speed_reg - prev_speed_reg
                                                  : prev_speed_reg - speed_reg;
        err       = (speed_reg >= target_reg) ? speed_reg - target_reg
                                              : target_reg - speed_reg;
        shift_sat = (shift_reg > ShiftWidth'(MaxShift)) ? ShiftWidth'(MaxShift) : shift_reg;
        dividend  = {{MaxShift{1'b0}}, err} << shift_sat;
        divisor   = {1'b0, change} + 1'b1;
    end

    msdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (corr)
    );

    // next duty level
    always_comb
    begin
        ramp_sum        = {1'b0, duty_level_reg} + (DutyWidth+1)'(step_reg);
        up_sum          = (CorrWidth+1)'(duty_level_reg) + {1'b0, corr};
        duty_level_next = duty_level_reg;
        capped_next     = 1'b0;
        if (!enabled)
        begin
            duty_level_next = '0;
        end
        else if (!running_reg)
        begin
            if (ramp_sum > {1'b0, cap_reg})
            begin
                duty_level_next = cap_reg;
                capped_next     = 1'b1;
            end
            else
            begin
                duty_level_next = ramp_sum[DutyWidth-1:0];
            end
        end
        else if (fresh_reg)
        begin
            if (speed_reg >= target_reg)
            begin
                if ((CorrWidth)'(duty_level_reg) > corr)
                begin
                    duty_level_next = duty_level_reg - corr[DutyWidth-1:0];
                end
            end
            else if (up_sum < (CorrWidth+1)'(ceil_reg))
            begin
                duty_level_next = up_sum[DutyWidth-1:0];
            end
        end
    end

    // regulator state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_level_reg <= '0;
            prev_speed_reg <= '0;
        end
        else if (cmd.commit)
        begin
            duty_level_reg <= duty_level_next;
            if (enabled)
            begin
                prev_speed_reg <= speed_reg;
            end
        end
    end

    // result register
    assign out_valid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_duty_reg   <= duty_level_next;
            out_capped_reg <= capped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataWidth-DutyWidth-1){1'b0}}, out_capped_reg, out_duty_reg};

    // status to the controller
    assign status.need_div = enabled && running_reg && fresh_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

/* rtl/core/msdr_ctrl.sv */
`default_nettype none

module msdr_ctrl
    import msdr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = status.need_div ? ST_DIVIDE : ST_UPDATE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready      = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_LOAD:   cmd.div_start = status.need_div;
            ST_DIVIDE: ;
            ST_UPDATE: cmd.commit = status.out_free;
            default:   ;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/motor_speed_duty_regulator.sv */
// Motor speed duty regulator: one PWM duty per control tick.
// Input stream (s_*): one transaction per tick carrying the measured speed,
// the motor running flag and the fresh measurement flag.
// Output stream (m_*): one transaction per input carrying the duty and the
// startup clamp flag.
// Configuration channel (cfg_*): register index and data, always ready; write
// only while no tick is in flight.
// Output path: the input is captured, the controller passes through ST_LOAD
// and, when a division is needed, ST_DIVIDE, then commits the result to the
// output register in ST_UPDATE. No division is needed when disabled, in the
// startup ramp, or with no fresh measurement; a correction is computed by the
// 24-step restoring divider that produces one quotient bit per cycle.
// Flow: one tick at a time; the next input is taken in the cycle after the
// previous result is loaded into the output register.
// Reset: duty level and previous speed clear to zero, registers go to their
// defaults (disabled, zero target, step 20, cap 800, ceiling 4000, shift 4).
// Stall: the result waits in the output register while m_tready is low; the
// next tick is accepted and processed meanwhile but holds before commit until
// the output register is free.
`default_nettype none

module motor_speed_duty_regulator
    import msdr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    // input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [InDataWidth-1:0]  s_tdata,  // measured_speed[15:0], motor_running, speed_fresh
    // output stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OutDataWidth-1:0]      m_tdata   // duty[11:0], startup_capped
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    msdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msdr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
